// ===== sv/perspective_point_projection_defines.svh =====
// Assertion macros used by the checker file ppp_checker.sv.
`ifndef PERSPECTIVE_POINT_PROJECTION_DEFINES_SVH
`define PERSPECTIVE_POINT_PROJECTION_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define PPP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define PPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/ppp_pkg.sv =====
`default_nettype none
package ppp_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int BASIS_FRAC = 14;
  localparam int COORD_W    = 32;
  localparam int INV_W      = 31;
  localparam int COMP_W     = 16;
  localparam int BAS_W      = 3 * COMP_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int CROSS_W    = 2 * COMP_W + 1;
  localparam int PROD_W     = DIFF_W + CROSS_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int DETP_W     = COMP_W + CROSS_W;
  localparam int DET_W      = DETP_W + 1;
  localparam int SH_P       = FRAC_BITS;
  localparam int SH_I       = 2 * FRAC_BITS - BASIS_FRAC;
  localparam int MAG_W      = SUM_W - 1;
  localparam int DMAG_W     = DET_W - 1;
  localparam int REM_W      = (MAG_W + SH_P > DMAG_W + SH_I) ? MAG_W + SH_P : DMAG_W + SH_I;
  localparam int DEN_W      = MAG_W;
  localparam int QB         = COORD_W - 1;
  localparam int CMP_W      = ((REM_W > DEN_W + QB) ? REM_W : DEN_W + QB) + 1;
  localparam int NST        = QB + 1;

  typedef struct packed {
    logic                       v;
    logic                       vis;
    logic                       binv;
    logic [2:0]                 neg;
    logic [2:0]                 sat;
    logic [2:0][REM_W-1:0]      rem;
    logic [DEN_W-1:0]           den;
    logic [2:0][QB-1:0]         q;
  } div_stage_t;
endpackage
`default_nettype wire

// ===== sv/ppp_point_if.sv =====
`default_nettype none
interface ppp_point_if import ppp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface
`default_nettype wire

// ===== sv/ppp_result_if.sv =====
`default_nettype none
interface ppp_result_if import ppp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      visible;
  logic signed [COORD_W-1:0] proj_x;
  logic signed [COORD_W-1:0] proj_y;
  logic [INV_W-1:0]          inv_depth;
  logic                      basis_invalid;
  modport source (output valid, visible, proj_x, proj_y, inv_depth, basis_invalid,
                  input ready);
  modport sink (input valid, visible, proj_x, proj_y, inv_depth, basis_invalid,
                output ready);
endinterface
`default_nettype wire

// ===== sv/perspective_point_projection.sv =====
// Throughput: one point per cycle while the output is not stalled. Most of the pipeline
// is the 32-stage restoring divider, which handles the saturation check and then one
// quotient bit per stage for all three quotients.
// A stalled output register freezes the whole pipeline.
// Reset (asynchronous, active low) empties the pipeline and loads the default camera.
`default_nettype none
module perspective_point_projection import ppp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppp_point_if.sink   pt_i,
  ppp_result_if.source res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  typedef enum logic [2:0] {
    REG_POS_X, REG_POS_Y, REG_POS_Z, REG_RIGHT, REG_UP, REG_FWD
  } reg_idx_e;

  localparam logic [BAS_W-1:0] RIGHT_RST = 48'h0000_0000_4000;
  localparam logic [BAS_W-1:0] UP_RST    = 48'h0000_4000_0000;
  localparam logic [BAS_W-1:0] FWD_RST   = 48'hC000_0000_0000;

  logic signed [COORD_W-1:0] pos_q [3];
  logic [BAS_W-1:0]          bas_q [3];
  logic                      wr_en;
  logic [2:0]                idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      pos_q[2] <= '0;
      bas_q[0] <= RIGHT_RST;
      bas_q[1] <= UP_RST;
      bas_q[2] <= FWD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_POS_X: pos_q[0] <= pwdata[COORD_W-1:0];
        REG_POS_Y: pos_q[1] <= pwdata[COORD_W-1:0];
        REG_POS_Z: pos_q[2] <= pwdata[COORD_W-1:0];
        REG_RIGHT: bas_q[0] <= pwdata[BAS_W-1:0];
        REG_UP:    bas_q[1] <= pwdata[BAS_W-1:0];
        REG_FWD:   bas_q[2] <= pwdata[BAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POS_X: prdata = {{(64-COORD_W){1'b0}}, pos_q[0]};
      REG_POS_Y: prdata = {{(64-COORD_W){1'b0}}, pos_q[1]};
      REG_POS_Z: prdata = {{(64-COORD_W){1'b0}}, pos_q[2]};
      REG_RIGHT: prdata = {{(64-BAS_W){1'b0}}, bas_q[0]};
      REG_UP:    prdata = {{(64-BAS_W){1'b0}}, bas_q[1]};
      REG_FWD:   prdata = {{(64-BAS_W){1'b0}}, bas_q[2]};
      default:   prdata = '0;
    endcase
  end

  // Camera-derived terms: rows are u x f, f x r and r x u; det = r . (u x f).
  logic signed [COMP_W-1:0]  bc [3][3];
  logic signed [CROSS_W-1:0] cr_d [3][3];
  logic signed [CROSS_W-1:0] cr_q [3][3];
  logic signed [DETP_W-1:0]  detp_q [3];
  logic signed [DET_W-1:0]   det_q;

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int c = 0; c < 3; c++) begin
        bc[v][c] = bas_q[v][c*COMP_W +: COMP_W];
      end
    end
    for (int k = 0; k < 3; k++) begin
      cr_d[k][0] = CROSS_W'(bc[(k+1)%3][1]) * CROSS_W'(bc[(k+2)%3][2])
                 - CROSS_W'(bc[(k+1)%3][2]) * CROSS_W'(bc[(k+2)%3][1]);
      cr_d[k][1] = CROSS_W'(bc[(k+1)%3][2]) * CROSS_W'(bc[(k+2)%3][0])
                 - CROSS_W'(bc[(k+1)%3][0]) * CROSS_W'(bc[(k+2)%3][2]);
      cr_d[k][2] = CROSS_W'(bc[(k+1)%3][0]) * CROSS_W'(bc[(k+2)%3][1])
                 - CROSS_W'(bc[(k+1)%3][1]) * CROSS_W'(bc[(k+2)%3][0]);
    end
  end

  always_ff @(posedge clk_i) begin
    cr_q <= cr_d;
    for (int c = 0; c < 3; c++) begin
      detp_q[c] <= DETP_W'(bc[0][c]) * DETP_W'(cr_q[0][c]);
    end
    det_q <= DET_W'(detp_q[0]) + DET_W'(detp_q[1]) + DET_W'(detp_q[2]);
  end

  // Point pipeline.
  logic                      en;
  logic                      v1_q, v2_q, v3_q;
  logic signed [DIFF_W-1:0]  d_q [3];
  logic signed [PROD_W-1:0]  prod_q [3][3];
  logic signed [SUM_W-1:0]   n_q [3];
  div_stage_t                dv_d [NST+1];
  div_stage_t                dv_q [NST+1];
  logic                      out_v_q;
  logic [SUM_W-1:0]          mag [2];
  logic [DET_W-1:0]          dmag;
  logic [SUM_W-1:0]          zmag;

  assign en         = !out_v_q || res_o.ready;
  assign pt_i.ready = en;
  assign res_o.valid = out_v_q;

  always_comb begin
    logic [CMP_W-1:0] trial;
    trial = '0;
    for (int l = 0; l < 2; l++) begin
      mag[l] = n_q[l][SUM_W-1] ? SUM_W'(-n_q[l]) : SUM_W'(n_q[l]);
    end
    zmag = n_q[2][SUM_W-1] ? SUM_W'(-n_q[2]) : SUM_W'(n_q[2]);
    dmag = det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);

    dv_d[0].v      = v3_q;
    dv_d[0].binv   = (det_q == '0);
    dv_d[0].vis    = (det_q != '0) && (n_q[2] != '0)
                   && (n_q[2][SUM_W-1] == det_q[DET_W-1]);
    dv_d[0].neg[0] = n_q[0][SUM_W-1] ^ n_q[2][SUM_W-1];
    dv_d[0].neg[1] = n_q[1][SUM_W-1] ^ n_q[2][SUM_W-1];
    dv_d[0].neg[2] = 1'b0;
    dv_d[0].sat    = '0;
    dv_d[0].rem[0] = REM_W'(mag[0][MAG_W-1:0]) << SH_P;
    dv_d[0].rem[1] = REM_W'(mag[1][MAG_W-1:0]) << SH_P;
    dv_d[0].rem[2] = REM_W'(dmag[DMAG_W-1:0]) << SH_I;
    dv_d[0].den    = zmag[DEN_W-1:0];
    dv_d[0].q      = '0;

    for (int s = 0; s < NST; s++) begin
      dv_d[s+1] = dv_q[s];
      for (int l = 0; l < 3; l++) begin
        if (s == 0) begin
          dv_d[s+1].sat[l] = CMP_W'(dv_q[s].rem[l]) >= (CMP_W'(dv_q[s].den) << QB);
        end else begin
          trial = CMP_W'(dv_q[s].den) << (QB - s);
          if (CMP_W'(dv_q[s].rem[l]) >= trial) begin
            dv_d[s+1].rem[l]      = dv_q[s].rem[l] - REM_W'(trial);
            dv_d[s+1].q[l][QB-s]  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
      for (int s = 0; s <= NST; s++) begin
        dv_q[s] <= '0;
      end
    end else if (en) begin
      v1_q    <= pt_i.valid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      out_v_q <= dv_q[NST].v;
      for (int s = 0; s <= NST; s++) begin
        dv_q[s] <= dv_d[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q[0] <= DIFF_W'(pt_i.point_x) - DIFF_W'(pos_q[0]);
      d_q[1] <= DIFF_W'(pt_i.point_y) - DIFF_W'(pos_q[1]);
      d_q[2] <= DIFF_W'(pt_i.point_z) - DIFF_W'(pos_q[2]);
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[k][c] <= PROD_W'(cr_q[k][c]) * PROD_W'(d_q[c]);
        end
        n_q[k] <= SUM_W'(prod_q[k][0]) + SUM_W'(prod_q[k][1]) + SUM_W'(prod_q[k][2]);
      end
      res_o.visible       <= dv_q[NST].vis;
      res_o.basis_invalid <= dv_q[NST].binv;
      if (!dv_q[NST].vis) begin
        res_o.proj_x <= '0;
      end else if (dv_q[NST].sat[0]) begin
        res_o.proj_x <= dv_q[NST].neg[0] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
      end else begin
        res_o.proj_x <= dv_q[NST].neg[0] ? -{1'b0, dv_q[NST].q[0]} : {1'b0, dv_q[NST].q[0]};
      end
      if (!dv_q[NST].vis) begin
        res_o.proj_y <= '0;
      end else if (dv_q[NST].sat[1]) begin
        res_o.proj_y <= dv_q[NST].neg[1] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
      end else begin
        res_o.proj_y <= dv_q[NST].neg[1] ? -{1'b0, dv_q[NST].q[1]} : {1'b0, dv_q[NST].q[1]};
      end
      if (!dv_q[NST].vis) begin
        res_o.inv_depth <= '0;
      end else begin
        res_o.inv_depth <= dv_q[NST].sat[2] ? {INV_W{1'b1}} : dv_q[NST].q[2];
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/ppp_checker.sv =====
`default_nettype none
`include "perspective_point_projection_defines.svh"
module ppp_checker import ppp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               visible,
  input logic               basis_invalid,
  input logic [COORD_W-1:0] proj_x,
  input logic [COORD_W-1:0] proj_y,
  input logic [INV_W-1:0]   inv_depth
);
  `PPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `PPP_ASSERT_NOW(a_stall_blocks_in, out_valid && !out_ready, !in_ready)
  `PPP_ASSERT_NOW(a_invalid_not_visible, out_valid && basis_invalid, !visible)
  `PPP_ASSERT_NOW(a_hidden_zero, out_valid && !visible,
                  proj_x == '0 && proj_y == '0 && inv_depth == '0)
endmodule

bind perspective_point_projection ppp_checker u_ppp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready      (pt_i.ready),
  .out_valid     (res_o.valid),
  .out_ready     (res_o.ready),
  .visible       (res_o.visible),
  .basis_invalid (res_o.basis_invalid),
  .proj_x        (res_o.proj_x),
  .proj_y        (res_o.proj_y),
  .inv_depth     (res_o.inv_depth)
);
`default_nettype wire

// ===== tb/ppp_tb_pkg.sv =====
`timescale 1ns / 100ps
package ppp_tb_pkg;
  typedef enum logic [2:0] {
    REG_CAM_X   = 3'd0,
    REG_CAM_Y   = 3'd1,
    REG_CAM_Z   = 3'd2,
    REG_RIGHT   = 3'd3,
    REG_UP      = 3'd4,
    REG_FORWARD = 3'd5
  } cam_reg_e;
endpackage

// ===== tb/perspective_point_projection_check.sv =====
`timescale 1ns / 100ps
module perspective_point_projection_check import ppp_pkg::*, ppp_tb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppp_point_if        pt,
  ppp_result_if       res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output int          errors_o,
  output int          pending_o
);

  typedef struct {
    logic                      vis;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [INV_W-1:0]          inv;
    logic                      binv;
  } proj_t;

  logic [COORD_W-1:0] cam_pos [3];
  logic [BAS_W-1:0]   basis [3];
  proj_t              proj_q [$];

  function automatic logic [31:0] sat_quot(logic signed [127:0] num,
                                           logic signed [127:0] den, int sh);
    logic [127:0] q;
    logic [127:0] an;
    logic [127:0] ad;
    logic         neg;
    neg = num[127] ^ den[127];
    an  = num[127] ? -num : num;
    ad  = den[127] ? -den : den;
    q   = (an << sh) / ad;
    if (neg) begin
      return (q >= 128'h8000_0000) ? 32'h8000_0000 : 32'h0 - q[31:0];
    end
    return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic proj_t project(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                    logic [COORD_W-1:0] pz);
    logic signed [127:0] r [3];
    logic signed [127:0] u [3];
    logic signed [127:0] f [3];
    logic signed [127:0] d [3];
    logic signed [127:0] a [3];
    logic signed [127:0] b [3];
    logic signed [127:0] c [3];
    logic signed [127:0] det;
    logic signed [127:0] nx;
    logic signed [127:0] ny;
    logic signed [127:0] nz;
    logic [COORD_W-1:0]  p [3];
    proj_t               o;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int k = 0; k < 3; k++) begin
      r[k] = signed'(basis[0][16*k +: 16]);
      u[k] = signed'(basis[1][16*k +: 16]);
      f[k] = signed'(basis[2][16*k +: 16]);
      d[k] = 128'(signed'(p[k])) - 128'(signed'(cam_pos[k]));
    end
    a[0] = u[1] * f[2] - u[2] * f[1];
    a[1] = u[2] * f[0] - u[0] * f[2];
    a[2] = u[0] * f[1] - u[1] * f[0];
    b[0] = f[1] * r[2] - f[2] * r[1];
    b[1] = f[2] * r[0] - f[0] * r[2];
    b[2] = f[0] * r[1] - f[1] * r[0];
    c[0] = r[1] * u[2] - r[2] * u[1];
    c[1] = r[2] * u[0] - r[0] * u[2];
    c[2] = r[0] * u[1] - r[1] * u[0];
    det = r[0] * a[0] + r[1] * a[1] + r[2] * a[2];
    o = '{vis: 1'b0, px: '0, py: '0, inv: '0, binv: 1'b0};
    if (det == 0) begin
      o.binv = 1'b1;
      return o;
    end
    nx = a[0] * d[0] + a[1] * d[1] + a[2] * d[2];
    ny = b[0] * d[0] + b[1] * d[1] + b[2] * d[2];
    nz = c[0] * d[0] + c[1] * d[1] + c[2] * d[2];
    if (nz == 0 || nz[127] != det[127]) return o;
    o.vis = 1'b1;
    o.px  = sat_quot(nx, nz, FRAC_BITS);
    o.py  = sat_quot(ny, nz, FRAC_BITS);
    o.inv = INV_W'(sat_quot(det, nz, 2 * FRAC_BITS - BASIS_FRAC));
    return o;
  endfunction

  task automatic report(string what, longint want, longint got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    proj_t want;
    if (!rst_ni) begin
      cam_pos   = '{default: '0};
      basis[0]  = 48'd16384;
      basis[1]  = 48'd1073741824;
      basis[2]  = 48'd211106232532992;
      errors_o  = 0;
      pending_o = 0;
      proj_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_CAM_X:   cam_pos[0] = pwdata[31:0];
          REG_CAM_Y:   cam_pos[1] = pwdata[31:0];
          REG_CAM_Z:   cam_pos[2] = pwdata[31:0];
          REG_RIGHT:   basis[0] = pwdata[47:0];
          REG_UP:      basis[1] = pwdata[47:0];
          REG_FORWARD: basis[2] = pwdata[47:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (proj_q.size() == 0) begin
          report("unexpected word", 0, 1);
        end else begin
          want = proj_q.pop_front();
          if (res.visible !== want.vis) report("visible", want.vis, res.visible);
          if (res.proj_x !== want.px) report("proj_x", want.px, res.proj_x);
          if (res.proj_y !== want.py) report("proj_y", want.py, res.proj_y);
          if (res.inv_depth !== want.inv) report("inv_depth", want.inv, res.inv_depth);
          if (res.basis_invalid !== want.binv) begin
            report("basis_invalid", want.binv, res.basis_invalid);
          end
        end
      end
      if (pt.valid && pt.ready) proj_q.push_back(project(pt.point_x, pt.point_y, pt.point_z));
      pending_o = proj_q.size();
    end
  end

endmodule

// ===== tb/perspective_point_projection_test.sv =====
`timescale 1ns / 100ps
module perspective_point_projection_test;
  import ppp_pkg::*;
  import ppp_tb_pkg::*;

  localparam int LATENCY = 37;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  bit          calm_in;
  bit          calm_out;
  int          stall_left;

  ppp_point_if  pt ();
  ppp_result_if res ();

  perspective_point_projection u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt),
    .res_o  (res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  perspective_point_projection_check u_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pt       (pt),
    .res      (res),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .errors_o (errors),
    .pending_o(pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int gap_len(bit calm);
    int r;
    r = $urandom_range(99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    res.ready  = 1'b0;
    stall_left = 0;
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      res.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res.ready <= 1'b1;
      if ($urandom_range(3) == 0) stall_left <= gap_len(calm_out);
    end
  end

  task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int g;
    g = gap_len(calm_in);
    if (g > 0) begin
      pt.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    pt.valid   <= 1'b1;
    pt.point_x <= x;
    pt.point_y <= y;
    pt.point_z <= z;
    do @(posedge clk_i); while (!pt.ready);
    @(negedge clk_i);
  endtask

  task automatic settle();
    pt.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  task automatic write_reg(cam_reg_e idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [47:0] r, logic [47:0] u, logic [47:0] f);
    settle();
    write_reg(REG_CAM_X, {32'h0, cx});
    write_reg(REG_CAM_Y, {32'h0, cy});
    write_reg(REG_CAM_Z, {32'h0, cz});
    write_reg(REG_RIGHT, {16'h0, r});
    write_reg(REG_UP, {16'h0, u});
    write_reg(REG_FORWARD, {16'h0, f});
  endtask

  function automatic logic [47:0] axis_vec(int axis, bit flip);
    logic [47:0] v;
    v = '0;
    v[16*axis +: 16] = flip ? 16'hC000 : 16'h4000;
    return v;
  endfunction

  function automatic logic [47:0] rand_vec();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  initial begin
    int          ax;
    int          bx;
    int          sel;
    logic [31:0] c [3];
    logic [31:0] span;
    logic [47:0] r;
    logic [47:0] u;
    logic [47:0] f;
    pt.valid   = 1'b0;
    pt.point_x = '0;
    pt.point_y = '0;
    pt.point_z = '0;
    calm_in    = 1'b0;
    calm_out   = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Default camera: zero depth, in front, behind, tiny depth and extreme coordinates.
    send(32'h0, 32'h0, 32'h0);
    send(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000);
    send(32'h0, 32'h0, 32'h0001_0000);
    send(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(32'h0, 32'h0, 32'h8000_0000);

    set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               48'h8000_7FFF_0000, 48'h7FFF_0000_8000, 48'h0000_8000_7FFF);
    send(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send(32'h0, 32'h0, 32'h0);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    set_camera(32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
               48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_4000);
    send(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
    send(32'h0, 32'h0, 32'h0);

    set_camera(32'h0, 32'h0, 32'h0, 48'h0, axis_vec(1, 0), axis_vec(2, 1));
    send(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);

    for (int ph = 0; ph < 12; ph++) begin
      calm_in  = (ph % 4 == 1);
      calm_out = (ph % 4 == 2);
      sel = $urandom_range(9);
      for (int k = 0; k < 3; k++) begin
        c[k] = (sel < 3) ? $urandom : 32'($signed($urandom_range(2000)) - 1000) << 12;
      end
      ax = $urandom_range(2);
      bx = (ax + 1 + $urandom_range(1)) % 3;
      r  = axis_vec(ax, $urandom_range(1));
      u  = axis_vec(bx, $urandom_range(1));
      f  = axis_vec(3 - ax - bx, $urandom_range(1));
      if (sel == 7) begin
        r = rand_vec();
        u = rand_vec();
        f = rand_vec();
      end else if (sel == 8) begin
        f = u;
      end else if (sel >= 5) begin
        r = r + {16'($urandom_range(255)), 16'($urandom_range(255)), 16'($urandom_range(255))};
        f = f - {16'($urandom_range(255)), 16'($urandom_range(255)), 16'($urandom_range(255))};
      end
      set_camera(c[0], c[1], c[2], r, u, f);
      for (int n = 0; n < 112; n++) begin
        if ($urandom_range(9) < 3) begin
          send($urandom, $urandom, $urandom);
        end else begin
          span = 32'h1 << $urandom_range(31);
          send(c[0] + ($urandom % span) - (span >> 1), c[1] + ($urandom % span) - (span >> 1),
               c[2] + ($urandom % span) - (span >> 1));
        end
      end
    end

    pt.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/ppp_pkg.sv
sv/ppp_point_if.sv
sv/ppp_result_if.sv
sv/perspective_point_projection.sv
sv/ppp_checker.sv
tb/ppp_tb_pkg.sv
tb/perspective_point_projection_check.sv
tb/perspective_point_projection_test.sv
